// ===== sv/byte_stream_tokenizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared shorthand for concurrent assertions clocked on clk and held off
// while rst is high.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_TOKENIZER_CORE_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define BST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Token kinds, scan modes, character codes and the result record types.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int TOK_W = 16;
  localparam int SLOTS = 3;

  typedef enum logic [2:0] {
    KIND_SYM   = 3'd0,
    KIND_INT   = 3'd1,
    KIND_FLOAT = 3'd2,
    KIND_WORD  = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  typedef struct packed {
    kind_t              kind;
    logic [TOK_W-1:0]   start;
    logic [TOK_W-1:0]   length;
    logic [7:0]         sym;
  } token_t;

  // All results caused by one input transaction, in delivery order.
  typedef struct packed {
    logic [1:0]             cnt;
    token_t [SLOTS-1:0]     slot;
  } row_t;

endpackage

// ===== sv/bst_lexer.sv =====
// ----------------------------------------------------------------------------
// Tokenizer scan state and classification
// Holds the open token and the byte position, and builds the result row
// for the byte in the input register.
// ----------------------------------------------------------------------------
module bst_lexer import bst_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_byte,
  input  logic       byte_valid,
  input  logic       end_of_input,
  output row_t       row
);

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  mode_t                scan_mode, scan_mode_next;
  logic                 dot_seen, dot_seen_next;
  logic [POS_WIDTH-1:0] open_start, open_start_next;
  logic [POS_WIDTH-1:0] open_length, open_length_next;
  logic [POS_WIDTH-1:0] byte_position, byte_position_next;

  logic is_digit, is_letter, is_blank, is_dot;
  logic grows, closes, starts, is_symbol, flushes, has_mid, mid_active;
  mode_t                mid_mode;
  logic                 mid_dot;
  logic [POS_WIDTH-1:0] mid_start, mid_len, mid_pos;
  kind_t  cur_kind, mid_kind;
  token_t tok_close, tok_mid, tok_end;

  always_comb begin
    is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    is_letter = ((char_byte >= CH_UP_A) && (char_byte <= CH_UP_Z)) ||
                ((char_byte >= CH_LO_A) && (char_byte <= CH_LO_Z));
    is_blank  = (char_byte == CH_SPACE) || (char_byte == CH_NL);
    is_dot    = (char_byte == CH_DOT);

    grows     = byte_valid &&
                (((scan_mode == MODE_NUM) && (is_digit || is_dot)) ||
                 ((scan_mode == MODE_WORD) && (is_digit || is_letter)));
    closes    = byte_valid && !grows &&
                ((scan_mode == MODE_NUM) || (scan_mode == MODE_WORD));
    starts    = byte_valid && !grows && (is_digit || is_letter);
    is_symbol = byte_valid && !grows && !is_blank && !is_digit && !is_letter;

    case (scan_mode)
      MODE_NUM: cur_kind = dot_seen ? KIND_FLOAT : KIND_INT;
      default:  cur_kind = KIND_WORD;
    endcase

    // State once the byte has been taken, before the end mark.
    mid_mode  = scan_mode;
    mid_dot   = dot_seen;
    mid_start = open_start;
    mid_len   = open_length;
    mid_pos   = byte_position;
    if (byte_valid) begin
      if (grows) begin
        if (open_length != POS_MAX) begin
          mid_len = open_length + 1'b1;
        end
        if (is_dot) begin
          mid_dot = 1'b1;
        end
      end else begin
        mid_mode = MODE_IDLE;
        if (closes) begin
          mid_dot = 1'b0;
          mid_len = '0;
        end
        if (starts) begin
          mid_mode  = is_digit ? MODE_NUM : MODE_WORD;
          mid_dot   = 1'b0;
          mid_start = byte_position;
          mid_len   = POS_WIDTH'(1);
        end
      end
      if (byte_position != POS_MAX) begin
        mid_pos = byte_position + 1'b1;
      end
    end

    mid_active = (mid_mode == MODE_NUM) || (mid_mode == MODE_WORD);
    case (mid_mode)
      MODE_NUM: mid_kind = mid_dot ? KIND_FLOAT : KIND_INT;
      default:  mid_kind = KIND_WORD;
    endcase
    flushes = end_of_input && mid_active;
    has_mid = is_symbol || flushes;

    scan_mode_next     = mid_mode;
    dot_seen_next      = mid_dot;
    open_start_next    = mid_start;
    open_length_next   = mid_len;
    byte_position_next = mid_pos;
    if (end_of_input) begin
      if (mid_active) begin
        scan_mode_next   = MODE_IDLE;
        dot_seen_next    = 1'b0;
        open_length_next = '0;
      end
      byte_position_next = '0;
      open_start_next    = '0;
    end

    tok_close = '{kind: cur_kind, start: TOK_W'(open_start),
                  length: TOK_W'(open_length), sym: 8'h00};
    tok_end   = '{kind: KIND_END, start: TOK_W'(mid_pos),
                  length: '0, sym: 8'h00};
    if (is_symbol) begin
      tok_mid = '{kind: KIND_SYM, start: TOK_W'(byte_position),
                  length: TOK_W'(1), sym: char_byte};
    end else begin
      tok_mid = '{kind: mid_kind, start: TOK_W'(mid_start),
                  length: TOK_W'(mid_len), sym: 8'h00};
    end

    // Closed token, then symbol or flushed token, then the end token.
    row.cnt     = 2'(closes) + 2'(has_mid) + 2'(end_of_input);
    row.slot[2] = tok_end;
    row.slot[1] = (closes && has_mid) ? tok_mid : tok_end;
    row.slot[0] = closes ? tok_close : (has_mid ? tok_mid : tok_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      dot_seen      <= 1'b0;
      open_start    <= '0;
      open_length   <= '0;
      byte_position <= '0;
    end else if (step) begin
      scan_mode     <= scan_mode_next;
      dot_seen      <= dot_seen_next;
      open_start    <= open_start_next;
      open_length   <= open_length_next;
      byte_position <= byte_position_next;
    end
  end

endmodule

// ===== sv/bst_rowq.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Two rows of up to three results each, delivered one result per
// transaction on the token channel.
// ----------------------------------------------------------------------------
module bst_rowq import bst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  row_t   push_row,
  output logic   can_push,
  output logic   token_valid,
  input  logic   token_stall,
  output token_t head,
  output logic   last_of_run
);

  localparam logic [1:0] DEPTH = 2'd2;

  row_t       rows [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic [1:0] slot;
  row_t       head_row;
  logic       take, pop;

  always_comb begin
    head_row    = rows[rd_ptr];
    head        = head_row.slot[slot];
    last_of_run = (slot == (head_row.cnt - 2'd1));
    token_valid = (count != 2'd0);
    take        = token_valid && !token_stall;
    pop         = take && last_of_run;
    can_push    = (count != DEPTH) || pop;
    count_next  = count + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rows[wr_ptr] <= push_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      slot   <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        slot   <= 2'd0;
      end else if (take) begin
        slot <= slot + 2'd1;
      end
    end
  end

endmodule

// ===== sv/byte_stream_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Byte stream tokenizer
// Splits ASCII bytes into integer, float, word, symbol and end tokens and
// reports each with its kind, start position and length.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ---------------------------------------
//   char     char_valid / char_stall char_byte, byte_valid, end_of_input
//   token    token_valid/token_stall token_kind, token_start, token_size,
//                                    symbol_char, last_of_run
//
// A char transaction is taken into the input register, classified in the
// following cycle and its one to three results go to the result queue as one
// row (no row if none). The queue returns one result per token transaction,
// so the block takes one byte per cycle while each byte yields at most one
// token and token_stall is low; the single result port gives one transaction
// per result. rst clears the scan state, the position and the queue. Stalls
// on the token side back up through the queue into char_stall.
//
module byte_stream_tokenizer_core import bst_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_byte,
  input  logic        byte_valid,
  input  logic        end_of_input,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [2:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_size,
  output logic [7:0]  symbol_char,
  output logic        last_of_run
);

  // Input register. The payload needs no reset; stage_valid says whether
  // it holds a transaction that has not yet been classified.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_bvalid;
  logic       stage_end;

  logic   advance, accept, can_push;
  row_t   row;
  token_t head;

  // The staged byte moves on as soon as the queue has room for its row.
  // Rows without any result are simply dropped, but the state still steps.
  assign advance    = stage_valid && can_push;
  assign char_stall = stage_valid && !advance;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte   <= char_byte;
      stage_bvalid <= byte_valid;
      stage_end    <= end_of_input;
    end
  end

  // Classification and scan state: one step per staged transaction.
  bst_lexer #(
    .POS_WIDTH (POS_WIDTH)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .char_byte    (stage_byte),
    .byte_valid   (stage_bvalid),
    .end_of_input (stage_end),
    .row          (row)
  );

  // Result queue: the output register that separates the two sides.
  bst_rowq u_rowq (
    .clk         (clk),
    .rst         (rst),
    .push        (advance && (row.cnt != 2'd0)),
    .push_row    (row),
    .can_push    (can_push),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .head        (head),
    .last_of_run (last_of_run)
  );

  assign token_kind  = head.kind;
  assign token_start = head.start;
  assign token_size  = head.length;
  assign symbol_char = head.sym;

endmodule

// ===== sv/bst_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the token channel of the tokenizer and is bound to its top level.
// ----------------------------------------------------------------------------
`include "byte_stream_tokenizer_core_macros.svh"

module bst_checker import bst_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        token_valid,
  input logic        token_stall,
  input logic [2:0]  token_kind,
  input logic [15:0] token_size,
  input logic [7:0]  symbol_char,
  input logic        last_of_run
);

  // A result held back by the receiver stays in place.
  `BST_ASSERT_NEXT(a_token_hold, token_valid && token_stall, token_valid && $stable(token_kind) && $stable(token_size) && $stable(last_of_run), "stalled token changed")

  // The end token is empty and always closes the run of its transaction.
  `BST_ASSERT(a_end_token, token_valid && (token_kind == KIND_END) |-> (token_size == 16'd0) && last_of_run, "bad end token")

  // A symbol covers exactly one byte.
  `BST_ASSERT(a_symbol_len, token_valid && (token_kind == KIND_SYM) |-> (token_size == 16'd1), "symbol length not one")

  // Only symbols carry a character.
  `BST_ASSERT(a_symbol_char, token_valid && (token_kind != KIND_SYM) |-> (symbol_char == 8'h00), "character on non-symbol")

endmodule

bind byte_stream_tokenizer_core bst_checker u_bst_checker (
  .clk         (clk),
  .rst         (rst),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token_kind  (token_kind),
  .token_size  (token_size),
  .symbol_char (symbol_char),
  .last_of_run (last_of_run)
);
